@@ rtl/lru_key_value_cache_macros.svh @@
// Assertion macros for the LRU key/value cache.
// Used by the top level; depends on nothing else.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LKVC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc: next-cycle check failed");

`endif

@@ rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// Used by lkvc_lookup, lkvc_lru and lru_key_value_cache; depends on nothing.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 31;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
  localparam logic [ADDR_W-3:0] REG_CAPACITY  = '0;

  typedef enum logic [0:0] {
    KIND_GET = 1'b0,
    KIND_SET = 1'b1
  } kind_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [ENTRIES-1:0][KEY_W-1:0]   key_table_t;
  typedef logic [ENTRIES-1:0][VALUE_W-1:0] value_table_t;

  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic hit;
    idx_t index;
  } lookup_t;

  typedef struct packed {
    logic             set_en;
    logic             hit;
    idx_t             hit_index;
    logic [CAP_W-1:0] capacity;
  } lru_req_t;

endpackage

@@ rtl/lkvc_lookup.sv @@
// Parallel key compare across every entry of the cache.
// Depends on lkvc_pkg.
module lkvc_lookup (
  input  logic [lkvc_pkg::KEY_W-1:0]   key,
  input  lkvc_pkg::key_table_t         keys,
  input  logic [lkvc_pkg::ENTRIES-1:0] valid,
  output lkvc_pkg::lookup_t            found
);

  always_comb begin
    found = '0;
    // Keys held are unique, so at most one entry matches.
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        found.hit   = 1'b1;
        found.index = lkvc_pkg::IDX_W'(i);
      end
    end
  end

endmodule

@@ rtl/lkvc_lru.sv @@
// Recency ranks, valid bits and occupancy; picks the entry a set writes.
// Depends on lkvc_pkg.
module lkvc_lru (
  input  logic                         clk,
  input  logic                         rst,
  input  lkvc_pkg::lru_req_t           req,
  output logic [lkvc_pkg::ENTRIES-1:0] valid,
  output lkvc_pkg::idx_t               target
);

  lkvc_pkg::age_t                 age      [lkvc_pkg::ENTRIES];
  lkvc_pkg::age_t                 age_next [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0]   valid_next;
  logic [lkvc_pkg::OCC_W-1:0]     occupancy;
  logic [lkvc_pkg::OCC_W-1:0]     occupancy_next;
  logic [lkvc_pkg::CMP_W-1:0]     eff_cap;
  logic                           full;
  logic                           insert;
  lkvc_pkg::age_t                 oldest;
  lkvc_pkg::age_t                 limit;
  lkvc_pkg::idx_t                 victim;
  lkvc_pkg::idx_t                 free_slot;

  always_comb begin
    eff_cap = lkvc_pkg::CMP_W'(req.capacity);
    if (req.capacity == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (lkvc_pkg::CMP_W'(req.capacity) > lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES)) begin
      eff_cap = lkvc_pkg::CMP_W'(lkvc_pkg::ENTRIES);
    end
    full   = lkvc_pkg::CMP_W'(occupancy) >= eff_cap;
    oldest = lkvc_pkg::AGE_W'(occupancy - lkvc_pkg::OCC_W'(1));

    // Ranks of valid entries are always 0 .. occupancy-1, so the least
    // recent entry is the one whose rank equals occupancy-1.
    victim    = '0;
    free_slot = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (valid[i] && age[i] == oldest) begin
        victim = lkvc_pkg::IDX_W'(i);
      end
    end
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = lkvc_pkg::IDX_W'(i);
      end
    end

    insert = !req.hit && !full;
    if (req.hit) begin
      target = req.hit_index;
      limit  = age[req.hit_index];
    end else if (full) begin
      target = victim;
      limit  = oldest;
    end else begin
      target = free_slot;
      limit  = '0;
    end

    valid_next     = valid;
    occupancy_next = occupancy;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      age_next[i] = age[i];
      if (req.set_en) begin
        if (valid[i] && (insert || age[i] < limit)) begin
          age_next[i] = age[i] + lkvc_pkg::AGE_W'(1);
        end
        if (target == lkvc_pkg::IDX_W'(i)) begin
          age_next[i] = '0;
        end
      end
    end
    if (req.set_en && insert) begin
      valid_next[target] = 1'b1;
      occupancy_next     = occupancy + lkvc_pkg::OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else begin
      valid     <= valid_next;
      occupancy <= occupancy_next;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        age[i] <= age_next[i];
      end
    end
  end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: configuration port, request and
// result registers, key and value storage. Depends on lkvc_pkg,
// lkvc_lookup, lkvc_lru and lru_key_value_cache_macros.svh.
//
// A request is taken in every clock cycle (busy stays low). It is held in the
// request register, where the parallel key compare and the recency update
// run, and a get produces its result in the cycle after that: done is high
// for exactly one cycle, with hit and read_value (zero on a miss). A set
// produces no transaction on the result side. The receiver cannot stall, so
// results must be taken when done is high. Capacity is written through the
// APB port at address 0 while the block is idle; the user, not the block,
// enforces this. 0 behaves as 1 and values above the table size as the size.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lkvc_pkg::request_t            request,
  output logic                          done,
  output lkvc_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  logic [lkvc_pkg::ADDR_W-3:0]  reg_index;
  logic                         req_vld;
  lkvc_pkg::request_t           req;
  lkvc_pkg::key_table_t         keys;
  lkvc_pkg::value_table_t       values;
  logic [lkvc_pkg::ENTRIES-1:0] valid;
  lkvc_pkg::lookup_t            found;
  lkvc_pkg::lru_req_t           lru_req;
  lkvc_pkg::idx_t               target;
  logic                         set_en;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register.
  assign reg_index = paddr[lkvc_pkg::ADDR_W-1:2];
  assign prdata    = (reg_index == lkvc_pkg::REG_CAPACITY) ?
                     lkvc_pkg::DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_index == lkvc_pkg::REG_CAPACITY) begin
      capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  lkvc_lookup u_lookup (
    .key   (req.key),
    .keys  (keys),
    .valid (valid),
    .found (found)
  );

  assign set_en = req_vld && (req.kind == lkvc_pkg::KIND_SET);

  always_comb begin
    lru_req.set_en    = set_en;
    lru_req.hit       = found.hit;
    lru_req.hit_index = found.index;
    lru_req.capacity  = capacity;
  end

  lkvc_lru u_lru (
    .clk    (clk),
    .rst    (rst),
    .req    (lru_req),
    .valid  (valid),
    .target (target)
  );

  // Key and value storage; contents only matter once the entry is valid.
  always_ff @(posedge clk) begin
    if (set_en) begin
      keys[target]   <= req.key;
      values[target] <= req.value;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_vld && (req.kind == lkvc_pkg::KIND_GET);
    end
  end

  always_ff @(posedge clk) begin
    result.hit        <= found.hit;
    result.read_value <= found.hit ? values[found.index] : '0;
  end

  `LKVC_ASSERT_NEXT(a_get_gives_result, clk, rst, req_vld && req.kind == lkvc_pkg::KIND_GET, done)
  `LKVC_ASSERT_NEXT(a_no_spurious_result, clk, rst, !(req_vld && req.kind == lkvc_pkg::KIND_GET), !done)
  `LKVC_ASSERT_IMP(a_miss_reads_zero, clk, rst, done && !result.hit, result.read_value == '0)
  `LKVC_ASSERT_IMP(a_hit_entry_valid, clk, rst, found.hit, valid[found.index])

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for lru_key_value_cache: a directed table of requests and
// capacity writes, then random phases, all checked against a behavioural LRU predictor.
// Depends on lkvc_pkg and the RTL top level only.
module tb;
  import lkvc_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 118;
  localparam int POOL_MAX = 32;
  localparam int RUN_LIMIT = 2000000;
  localparam logic [ADDR_W-3:0] REG_UNUSED = 1'b1;

  typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_act_t;

  typedef struct {
    row_act_t              act;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     data;
    request_t              req;
    bit                    pinned;
    result_t               want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  request_t            request;
  logic                done;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Travels with the request so that a table row can fix its own expected answer.
  bit                  fixed_answer_en;
  result_t             fixed_answer;

  // Predicted contents of the cache.
  logic [KEY_W-1:0]    cache_key [ENTRIES];
  logic [VALUE_W-1:0]  cache_val [ENTRIES];
  bit                  cache_vld [ENTRIES];
  age_t                cache_age [ENTRIES];
  int                  cache_occ;
  logic [CAP_W-1:0]    cap_reg;

  result_t             pending_reads [$];
  stim_row_t           directed [$];
  logic [KEY_W-1:0]    key_pool [POOL_MAX];
  logic [CAP_W-1:0]    phase_cap [PHASES];

  int                  mismatches;
  int                  n_gets;
  int                  n_hits;
  int                  n_sets;
  int                  n_evictions;
  int                  n_cap_writes;

  lru_key_value_cache DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
    if (cap == '0) return 1;
    if (int'(cap) > ENTRIES) return ENTRIES;
    return int'(cap);
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(input logic [ADDR_W-3:0] idx);
    return {idx, 2'b00};
  endfunction

  // Every valid entry more recent than the limit (or all of them) ages by one.
  function automatic void age_younger(input age_t limit, input bit all);
    for (int i = 0; i < ENTRIES; i++)
      if (cache_vld[i] && (all || cache_age[i] < limit)) cache_age[i] = cache_age[i] + 1'b1;
  endfunction

  function automatic void lookup_and_update(input request_t r, output bit produced,
                                            output result_t res);
    int found;
    int slot;
    found = -1;
    slot = -1;
    res = '0;
    produced = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && cache_vld[i] && cache_key[i] == r.key) found = i;

    if (r.kind == KIND_GET) begin
      produced = 1'b1;
      res.hit = (found >= 0);
      res.read_value = (found >= 0) ? cache_val[found] : '0;
      n_gets++;
      if (found >= 0) n_hits++;
      return;
    end

    n_sets++;
    if (found >= 0) begin
      age_younger(cache_age[found], 1'b0);
      cache_val[found] = r.value;
      cache_age[found] = '0;
      return;
    end

    if (cache_occ >= effective_capacity(cap_reg)) begin
      // The oldest valid entry makes way; a lowered capacity never shrinks the table.
      for (int i = 0; i < ENTRIES; i++)
        if (cache_vld[i] && (slot < 0 || cache_age[i] > cache_age[slot])) slot = i;
      if (slot < 0) return;
      age_younger(cache_age[slot], 1'b0);
      n_evictions++;
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !cache_vld[i]) slot = i;
      if (slot < 0) return;
      age_younger('0, 1'b1);
      cache_vld[slot] = 1'b1;
      cache_occ++;
    end
    cache_key[slot] = r.key;
    cache_val[slot] = r.value;
    cache_age[slot] = '0;
  endfunction

  always @(posedge clk) begin : monitor
    bit produced;
    result_t predicted;
    result_t wanted;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cache_vld[i] = 1'b0;
        cache_age[i] = '0;
      end
      cache_occ = 0;
      cap_reg = CAPACITY_RESET;
      pending_reads.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_CAPACITY)
        cap_reg = pwdata[CAP_W-1:0];
      if (start && busy === 1'b0) begin
        lookup_and_update(request, produced, predicted);
        if (produced) pending_reads.push_back(fixed_answer_en ? fixed_answer : predicted);
      end
      if (done) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("result strobe with no get outstanding");
        end else begin
          wanted = pending_reads.pop_front();
          if (result.hit !== wanted.hit)
            report_mismatch($sformatf("hit %b, expected %b", result.hit, wanted.hit));
          if (result.read_value !== wanted.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      result.read_value, wanted.read_value));
        end
      end
    end
  end

  // Drives one request and returns at the edge that accepts it; start is left high.
  task automatic issue(input request_t r, input int gap, input bit pin, input result_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    fixed_answer_en <= pin;
    fixed_answer <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Stops the request stream until every get has answered and sets have drained.
  task automatic settle();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_capacity();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, reg_addr(REG_CAPACITY), '0, rd);
    if (rd !== DATA_W'(cap_reg))
      report_mismatch($sformatf("capacity reads %h, expected %h", rd, cap_reg));
  endtask

  // Also reads capacity back, which shows that a write to an unused address was dropped.
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    settle();
    apb_access(1'b1, addr, data, rd);
    n_cap_writes++;
    read_capacity();
  endtask

  function automatic stim_row_t req_row(input kind_t kind, input logic [KEY_W-1:0] key,
                                        input logic [VALUE_W-1:0] value, input bit pinned,
                                        input bit hit, input logic [VALUE_W-1:0] rv);
    stim_row_t row;
    row.act = ROW_REQUEST;
    row.addr = '0;
    row.data = '0;
    row.req.kind = kind;
    row.req.key = key;
    row.req.value = value;
    row.pinned = pinned;
    row.want.hit = hit;
    row.want.read_value = rv;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] data);
    stim_row_t row;
    row = req_row(KIND_GET, '0, '0, 1'b0, 1'b0, '0);
    row.act = ROW_CONFIG;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  initial begin : limit
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    request_t r;
    logic [DATA_W-1:0] wdata;
    int gap;
    int sel;
    int pool_size;

    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    fixed_answer_en <= 1'b0;
    fixed_answer <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatches = 0;
    n_gets = 0;
    n_hits = 0;
    n_sets = 0;
    n_evictions = 0;
    n_cap_writes = 0;

    // Extreme keys and values, an update in place, capacity zero and above the table size,
    // eviction after capacity is lowered below occupancy, and a write to an unused address.
    directed.push_back(req_row(KIND_GET, 32'h0000_0000, 31'h0, 1'b1, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'hFFFF_FFFF, 31'h0, 1'b1, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_SET, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_SET, 32'hFFFF_FFFF, 31'h0, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h0000_0000, 31'h0, 1'b1, 1'b1, 31'h7FFF_FFFF));
    directed.push_back(req_row(KIND_GET, 32'hFFFF_FFFF, 31'h0, 1'b1, 1'b1, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h0000_0001, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_SET, 32'h0000_0000, 31'h2AAA_AAAA, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h0000_0000, 31'h0, 1'b1, 1'b1, 31'h2AAA_AAAA));
    directed.push_back(cfg_row(reg_addr(REG_CAPACITY), 32'hFFFF_FFE0));
    directed.push_back(req_row(KIND_SET, 32'h5555_5555, 31'h5555_5555, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'hFFFF_FFFF, 31'h0, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h0000_0000, 31'h0, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_SET, 32'hAAAA_AAAA, 31'h1, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h5555_5555, 31'h0, 1'b0, 1'b0, 31'h0));
    directed.push_back(cfg_row(reg_addr(REG_UNUSED), 32'h0000_0003));
    directed.push_back(req_row(KIND_SET, 32'h1234_5678, 31'h3, 1'b0, 1'b0, 31'h0));
    directed.push_back(cfg_row(reg_addr(REG_CAPACITY), 32'h0000_001F));
    directed.push_back(req_row(KIND_SET, 32'h0000_0001, 31'h1, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_SET, 32'h0000_0002, 31'h2, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h1234_5678, 31'h0, 1'b0, 1'b0, 31'h0));
    directed.push_back(req_row(KIND_GET, 32'h0000_0001, 31'h0, 1'b0, 1'b0, 31'h0));
    directed.push_back(cfg_row(reg_addr(REG_CAPACITY), 32'h0000_0010));

    phase_cap = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd8, 5'd3, 5'd16, 5'd5, 5'd20, 5'd12};
    phase_cap[5] = CAP_W'($urandom_range(3, 15));
    phase_cap[9] = CAP_W'($urandom_range(17, 30));
    phase_cap[PHASES-1] = CAP_W'($urandom_range(0, 31));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_capacity();

    foreach (directed[n]) begin
      if (directed[n].act == ROW_CONFIG)
        write_register(directed[n].addr, directed[n].data);
      else
        issue(directed[n].req, 0, directed[n].pinned, directed[n].want);
    end

    // Each phase keeps the table from the one before, so a smaller capacity
    // meets a fuller table. Keys come mostly from a pool just larger than capacity.
    for (int p = 0; p < PHASES; p++) begin
      if (p % 4 == 3) write_register(reg_addr(REG_UNUSED), $urandom);
      wdata = $urandom;
      wdata[CAP_W-1:0] = phase_cap[p];
      write_register(reg_addr(REG_CAPACITY), wdata);
      pool_size = effective_capacity(phase_cap[p]) + $urandom_range(1, 8);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (int k = 0; k < pool_size; k++) key_pool[k] = $urandom;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 || $urandom_range(0, 63) == 0) settle();
        r.kind = kind_t'($urandom_range(0, 1));
        sel = $urandom_range(0, 19);
        if (sel < 2) r.key = $urandom;
        else if (sel == 2) r.key = '0;
        else if (sel == 3) r.key = '1;
        else r.key = key_pool[$urandom_range(0, pool_size - 1)];
        sel = $urandom_range(0, 7);
        if (sel == 0) r.value = '1;
        else if (sel == 1) r.value = '0;
        else r.value = VALUE_W'($urandom);
        case (p % 3)
          0: gap = 0;
          1: gap = $urandom_range(0, 16);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        endcase
        issue(r, gap, 1'b0, '0);
      end
    end

    settle();
    $display("Covered %0d requests: %0d gets with %0d hits, %0d sets with %0d evictions.",
             n_gets + n_sets, n_gets, n_hits, n_sets, n_evictions);
    $display("%0d register writes, capacities from zero to above the table size.",
             n_cap_writes);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_lookup.sv
rtl/lkvc_lru.sv
rtl/lru_key_value_cache.sv
verif/tb.sv
